>>> hw/rtl/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg: shared types and constants for the transform matrix builder.
// Holds the payload structs, opcodes, the CORDIC arctangent table and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tmb_pkg;

  // Opcodes of an input transaction.
  localparam logic [2:0] OP_IDENT  = 3'd0;
  localparam logic [2:0] OP_TRANS  = 3'd1;
  localparam logic [2:0] OP_SCALE  = 3'd2;
  localparam logic [2:0] OP_ROTX   = 3'd3;
  localparam logic [2:0] OP_ROTY   = 3'd4;
  localparam logic [2:0] OP_ROTZ   = 3'd5;
  localparam logic [2:0] OP_VERTEX = 3'd6;

  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
  localparam logic signed [33:0] FULL_TURN = 34'sd23592960;
  localparam logic signed [33:0] HALF_TURN = 34'sd11796480;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd5898240;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam int ATAN_ENTRIES = 24;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_c;
    logic signed [31:0] arg_d;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;       // capture the input transaction
    logic       ident;      // reload identity
    logic       red_step;   // one angle reduction step
    logic       cordic_init;
    logic       cordic_step;
    logic       cordic_done; // round and clamp sine and cosine
    logic       mac_clr;    // clear the accumulator
    logic       mac_step;   // one multiply-accumulate
    logic       elem_store; // store the accumulator into the result column
    logic       commit;     // copy next matrix into the matrix
    logic       vert_store; // store the accumulator into the vertex result
    logic [4:0] iter;       // CORDIC iteration index
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] k;
  } tmb_cmd_t;

  typedef struct packed {
    logic       red_done;
  } tmb_sts_t;

  // atan(2^-i) in Q16.16 degrees.
  function automatic logic signed [33:0] atan_deg(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0: v = 34'sd2949120;   5'd1: v = 34'sd1740967;
      5'd2: v = 34'sd919880;    5'd3: v = 34'sd466945;
      5'd4: v = 34'sd234379;    5'd5: v = 34'sd117304;
      5'd6: v = 34'sd58666;     5'd7: v = 34'sd29335;
      5'd8: v = 34'sd14668;     5'd9: v = 34'sd7334;
      5'd10: v = 34'sd3667;     5'd11: v = 34'sd1833;
      5'd12: v = 34'sd917;      5'd13: v = 34'sd458;
      5'd14: v = 34'sd229;      5'd15: v = 34'sd115;
      5'd16: v = 34'sd57;       5'd17: v = 34'sd29;
      5'd18: v = 34'sd14;       5'd19: v = 34'sd7;
      5'd20: v = 34'sd4;        5'd21: v = 34'sd2;
      5'd22: v = 34'sd1;        default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/transform_matrix_builder.sv
// Identity loads directly; translate, scale and vertex run the multiply-add
// loops on the single shared multiplier, and rotations first run angle
// reduction and the CORDIC iterations. One transaction at a time: input
// stalls while the sequencer is busy or while a result waits.
// Reset (synchronous, active low) loads identity and clears all handshakes.
// ----------------------------------------------------------------------------
// transform_matrix_builder: top level.
// Joins the sequencer and the datapath of the Q16.16 4x4 transform builder.
// ----------------------------------------------------------------------------
`default_nettype none

module transform_matrix_builder #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tmb_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tmb_pkg::out_item_t      out_data
);

  tmb_pkg::tmb_cmd_t cmd;
  tmb_pkg::tmb_sts_t sts;

  tmb_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode(in_data.opcode),
    .out_valid, .out_stall, .sts, .cmd
  );

  tmb_dp u_dp (
    .clk, .rst_n, .in_data, .cmd, .sts, .out_data
  );

endmodule

`default_nettype wire

>>> hw/rtl/tmb_ctrl.sv
// ----------------------------------------------------------------------------
// tmb_ctrl: sequencer for the transform matrix builder.
// Steps through angle reduction, CORDIC iterations and the multiply-add
// loops, issuing one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [2:0]      in_opcode,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire tmb_pkg::tmb_sts_t sts,
  output tmb_pkg::tmb_cmd_t    cmd
);

  localparam int NSTEPS = (CORDIC_STEPS < tmb_pkg::ATAN_ENTRIES) ?
                          CORDIC_STEPS : tmb_pkg::ATAN_ENTRIES;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RED    = 3'd1;
  localparam logic [2:0] S_CORD   = 3'd2;
  localparam logic [2:0] S_TRIG   = 3'd3;
  localparam logic [2:0] S_MAC    = 3'd4;
  localparam logic [2:0] S_STORE  = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] op_r, op_nxt;
  logic [4:0] iter_r, iter_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] col_r, col_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;

  // Next-state and command decode.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    iter_nxt  = iter_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    k_nxt     = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '0;
    cmd.iter = iter_r;
    cmd.row  = row_r;
    cmd.col  = col_r;
    cmd.k    = k_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          op_nxt   = in_opcode;
          row_nxt  = '0;
          col_nxt  = '0;
          k_nxt    = '0;
          iter_nxt = '0;
          case (in_opcode)
            tmb_pkg::OP_IDENT: cmd.ident = 1'b1;
            tmb_pkg::OP_TRANS, tmb_pkg::OP_SCALE, tmb_pkg::OP_VERTEX: begin
              cmd.mac_clr = 1'b1;
              state_nxt   = S_MAC;
            end
            tmb_pkg::OP_ROTX, tmb_pkg::OP_ROTY, tmb_pkg::OP_ROTZ:
              state_nxt = S_RED;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RED: begin
        cmd.red_step = 1'b1;
        if (sts.red_done) begin
          cmd.red_step    = 1'b0;
          cmd.cordic_init = 1'b1;
          state_nxt = (NSTEPS == 0) ? S_TRIG : S_CORD;
        end
      end
      S_CORD: begin
        cmd.cordic_step = 1'b1;
        iter_nxt = iter_r + 5'd1;
        if (iter_r == 5'(NSTEPS - 1)) state_nxt = S_TRIG;
      end
      S_TRIG: begin
        cmd.cordic_done = 1'b1;
        cmd.mac_clr     = 1'b1;
        state_nxt       = S_MAC;
      end
      S_MAC: begin
        cmd.mac_step = 1'b1;
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd3) state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.mac_clr = 1'b1;
        if (op_r == tmb_pkg::OP_VERTEX) begin
          cmd.vert_store = 1'b1;
          col_nxt = col_r + 2'd1;
          if (col_r == 2'd3) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_MAC;
          end
        end else begin
          cmd.elem_store = 1'b1;
          col_nxt = col_r + 2'd1;
          if (col_r == 2'd3) row_nxt = row_r + 2'd1;
          if (col_r == 2'd3 && row_r == 2'd3) state_nxt = S_COMMIT;
          else state_nxt = S_MAC;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      op_r  <= '0;
      iter_r <= '0;
      row_r <= '0;
      col_r <= '0;
      k_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      op_r  <= op_nxt;
      iter_r <= iter_nxt;
      row_r <= row_nxt;
      col_r <= col_nxt;
      k_r   <= k_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tmb_dp.sv
// ----------------------------------------------------------------------------
// tmb_dp: datapath of the transform matrix builder.
// Holds the matrix, the angle reduction, the CORDIC unit and one shared
// 32x32 multiplier with a rounding accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tmb_pkg::in_item_t  in_data,
  input  wire tmb_pkg::tmb_cmd_t  cmd,
  output tmb_pkg::tmb_sts_t       sts,
  output tmb_pkg::out_item_t      out_data
);

  logic signed [31:0] mat_r [16];
  logic signed [31:0] nxt_r [16];
  tmb_pkg::in_item_t  item_r;
  logic signed [33:0] z_r, z_nxt;
  logic               flip_r, flip_nxt;
  logic signed [33:0] cx_r, cy_r;
  logic signed [31:0] sin_r, cos_r;
  logic signed [63:0] prod_r;
  logic               prod_v_r;
  logic signed [49:0] acc_r;
  tmb_pkg::out_item_t vert_r;

  // Largest power-of-two multiple of a full turn that one reduction step
  // may remove: lowering keeps the angle above minus a half turn, raising
  // keeps it at most a half turn.
  logic signed [33:0] turn_sub, turn_add;
  always_comb begin
    turn_sub = tmb_pkg::FULL_TURN;
    turn_add = tmb_pkg::FULL_TURN;
    for (int j = 1; j < 7; j++) begin
      if (z_r - (tmb_pkg::FULL_TURN <<< j) > -tmb_pkg::HALF_TURN)
        turn_sub = tmb_pkg::FULL_TURN <<< j;
      if (z_r + (tmb_pkg::FULL_TURN <<< j) <= tmb_pkg::HALF_TURN)
        turn_add = tmb_pkg::FULL_TURN <<< j;
    end
  end

  // Angle reduction: one turn-multiple step or one half-turn fold per cycle.
  always_comb begin
    z_nxt    = z_r;
    flip_nxt = flip_r;
    sts.red_done = 1'b0;
    if (z_r > tmb_pkg::HALF_TURN) begin
      z_nxt = z_r - turn_sub;
    end else if (z_r <= -tmb_pkg::HALF_TURN) begin
      z_nxt = z_r + turn_add;
    end else if (z_r > tmb_pkg::QUARTER_TURN) begin
      z_nxt = z_r - tmb_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end else if (z_r < -tmb_pkg::QUARTER_TURN) begin
      z_nxt = z_r + tmb_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end else begin
      sts.red_done = 1'b1;
    end
  end

  // CORDIC rotation, one iteration per cycle.
  logic signed [33:0] dx, dy, at;
  logic signed [34:0] cos_w, sin_w;
  logic signed [34:0] cos_f, sin_f;
  assign dx = cy_r >>> cmd.iter;
  assign dy = cx_r >>> cmd.iter;
  assign at = tmb_pkg::atan_deg(cmd.iter);
  assign cos_w = 35'((cx_r + 34'sd8192) >>> 14);
  assign sin_w = 35'((cy_r + 34'sd8192) >>> 14);
  assign cos_f = flip_r ? -cos_w : cos_w;
  assign sin_f = flip_r ? -sin_w : sin_w;

  function automatic logic signed [31:0] clamp_unit(input logic signed [34:0] v);
    if (v > 35'sd65536) return tmb_pkg::ONE_Q16;
    if (v < -35'sd65536) return -tmb_pkg::ONE_Q16;
    return v[31:0];
  endfunction

  // Operand element O[row][k] for the current opcode.
  function automatic logic signed [31:0] operand(
      input logic [2:0] op, input logic [1:0] r, input logic [1:0] k,
      input tmb_pkg::in_item_t it, input logic signed [31:0] s,
      input logic signed [31:0] c);
    logic signed [31:0] v;
    v = (r == k) ? tmb_pkg::ONE_Q16 : 32'sd0;
    case (op)
      tmb_pkg::OP_TRANS: begin
        if (r == 2'd3 && k == 2'd0) v = it.arg_a;
        if (r == 2'd3 && k == 2'd1) v = it.arg_b;
        if (r == 2'd3 && k == 2'd2) v = it.arg_c;
      end
      tmb_pkg::OP_SCALE: begin
        if (r == 2'd0 && k == 2'd0) v = it.arg_a;
        if (r == 2'd1 && k == 2'd1) v = it.arg_b;
        if (r == 2'd2 && k == 2'd2) v = it.arg_c;
      end
      tmb_pkg::OP_ROTX: begin
        if ((r == 2'd1 && k == 2'd1) || (r == 2'd2 && k == 2'd2)) v = c;
        if (r == 2'd2 && k == 2'd1) v = -s;
        if (r == 2'd1 && k == 2'd2) v = s;
      end
      tmb_pkg::OP_ROTY: begin
        if ((r == 2'd0 && k == 2'd0) || (r == 2'd2 && k == 2'd2)) v = c;
        if (r == 2'd2 && k == 2'd0) v = s;
        if (r == 2'd0 && k == 2'd2) v = -s;
      end
      tmb_pkg::OP_ROTZ: begin
        if ((r == 2'd0 && k == 2'd0) || (r == 2'd1 && k == 2'd1)) v = c;
        if (r == 2'd1 && k == 2'd0) v = -s;
        if (r == 2'd0 && k == 2'd1) v = s;
      end
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Multiplier operands: compose uses O[row][k] * M[k][col], vertex uses
  // M[k][col] * v[k].
  logic signed [31:0] mul_a, mul_b, vk;
  always_comb begin
    case (cmd.k)
      2'd0: vk = item_r.arg_a;
      2'd1: vk = item_r.arg_b;
      2'd2: vk = item_r.arg_c;
      default: vk = item_r.arg_d;
    endcase
    mul_b = mat_r[{cmd.k, cmd.col}];
    if (item_r.opcode == tmb_pkg::OP_VERTEX) mul_a = vk;
    else mul_a = operand(item_r.opcode, cmd.row, cmd.k, item_r, sin_r, cos_r);
  end

  // Signed 32x32 product, rounded to Q16.16 and summed exactly.
  logic signed [63:0] prod_w;
  logic signed [47:0] rnd;
  logic signed [49:0] acc_sum;
  assign prod_w = mul_a * mul_b;
  assign rnd = 48'((prod_r + 64'sd32768) >>> 16);
  assign acc_sum = acc_r + 50'(rnd);

  // Product stage and accumulator; the accumulator adds one registered
  // product per cycle after the multiplier stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= cmd.mac_step;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_w;
    if (cmd.mac_clr) acc_r <= '0;
    else if (prod_v_r) acc_r <= acc_sum;
  end

  // Matrix, operand capture, reduction and CORDIC registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++)
        mat_r[i] <= (i % 5 == 0) ? tmb_pkg::ONE_Q16 : 32'sd0;
    end else begin
      if (cmd.ident) begin
        for (int i = 0; i < 16; i++)
          mat_r[i] <= (i % 5 == 0) ? tmb_pkg::ONE_Q16 : 32'sd0;
      end else if (cmd.commit) begin
        for (int i = 0; i < 16; i++) mat_r[i] <= nxt_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      z_r    <= 34'(in_data.arg_a);
      flip_r <= 1'b0;
    end else if (cmd.red_step) begin
      z_r    <= z_nxt;
      flip_r <= flip_nxt;
    end else if (cmd.cordic_init) begin
      cx_r <= tmb_pkg::GAIN_Q30;
      cy_r <= '0;
    end else if (cmd.cordic_step) begin
      if (!z_r[33]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - at;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + at;
      end
    end
    if (cmd.cordic_done) begin
      cos_r <= clamp_unit(cos_f);
      sin_r <= clamp_unit(sin_f);
    end
  end

  // Result stores; the final product is added combinationally on the store
  // cycle, so the stored value includes it.
  logic signed [49:0] fin;
  logic signed [31:0] fin_sat;
  assign fin = acc_sum;
  always_comb begin
    if (fin > 50'sd2147483647) fin_sat = 32'sh7fffffff;
    else if (fin < -50'sd2147483648) fin_sat = 32'sh80000000;
    else fin_sat = fin[31:0];
  end

  logic [3:0] st_idx;
  assign st_idx = {cmd.row, cmd.col};

  always_ff @(posedge clk) begin
    if (cmd.elem_store) nxt_r[st_idx] <= fin_sat;
    if (cmd.vert_store) begin
      case (cmd.col)
        2'd0: vert_r.out_x <= fin_sat;
        2'd1: vert_r.out_y <= fin_sat;
        2'd2: vert_r.out_z <= fin_sat;
        default: vert_r.out_w <= fin_sat;
      endcase
    end
  end

  assign out_data = vert_r;

endmodule

`default_nettype wire

>>> hw/rtl/tmb_checker.sv
// ----------------------------------------------------------------------------
// tmb_checker: port-level checks for the transform matrix builder.
// Watches handshakes and result ordering on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module tmb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire tmb_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire tmb_pkg::out_item_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A stalled input transaction stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // A result never appears in the cycle right after an accepted transaction.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result too early");

  // While a result waits, no new transaction is taken.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("accepted while result pending");

  // After reset the result channel is empty.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind transform_matrix_builder tmb_checker u_tmb_checker (.*);

`default_nettype wire

>>> test/tb_transform_matrix_builder.sv
// ----------------------------------------------------------------------------
// tb_transform_matrix_builder: self-checking bench for the transform builder.
// Drives opcode transactions through a queue-fed driver, predicts the Q16.16
// matrix state and vertex results in the bench, and checks every result
// transaction field by field under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_transform_matrix_builder;

  localparam int CORDIC_STEPS = 16;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  tmb_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  tmb_pkg::out_item_t out_data;

  transform_matrix_builder #(.CORDIC_STEPS(CORDIC_STEPS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tmb_pkg::in_item_t  pending_q[$];
  tmb_pkg::out_item_t vertex_q[$];
  logic signed [31:0] mat [16];
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   phase_num = -1;
  logic long_hold;
  int   errors = 0;
  int   vertex_count = 0;
  int   accepted = 0;

  // Arithmetic shift is floor for signed operands.
  function automatic longint round_mul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic longint atan_q16(int i);
    longint t [24] = '{2949120, 1740967, 919880, 466945, 234379, 117304, 58666,
                       29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                       29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  // Angle reduction followed by a rotation-mode CORDIC.
  task automatic sine_cosine(input longint angle, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    z = angle % 23592960;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z < 0) z += 23592960;
    if (z > 11796480) z -= 23592960;
    if (z > 5898240) begin
      z -= 11796480;
      flip = 1;
    end else if (z < -5898240) begin
      z += 11796480;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q16(i);
      end else begin
        x += dx; y -= dy; z += atan_q16(i);
      end
    end
    x = (x + 8192) >>> 14;
    y = (y + 8192) >>> 14;
    if (flip) begin
      x = -x; y = -y;
    end
    cs = clamp_unit(x);
    sn = clamp_unit(y);
  endtask

  // Applies one accepted transaction to the matrix model.
  task automatic apply_transaction(input tmb_pkg::in_item_t t);
    longint op [16];
    longint sn, cs, acc;
    logic signed [31:0] nxt [16];
    tmb_pkg::out_item_t res;
    for (int i = 0; i < 16; i++) op[i] = (i % 5 == 0) ? 65536 : 0;
    if (t.opcode == tmb_pkg::OP_IDENT) begin
      for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
    end else if (t.opcode == tmb_pkg::OP_VERTEX) begin
      longint v [4];
      logic signed [31:0] r [4];
      v[0] = t.arg_a; v[1] = t.arg_b; v[2] = t.arg_c; v[3] = t.arg_d;
      for (int c = 0; c < 4; c++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += round_mul(mat[k*4+c], v[k]);
        r[c] = sat32(acc);
      end
      res.out_x = r[0]; res.out_y = r[1]; res.out_z = r[2]; res.out_w = r[3];
      vertex_q.push_back(res);
    end else if (t.opcode >= tmb_pkg::OP_TRANS && t.opcode <= tmb_pkg::OP_ROTZ) begin
      case (t.opcode)
        tmb_pkg::OP_TRANS: begin
          op[12] = t.arg_a; op[13] = t.arg_b; op[14] = t.arg_c;
        end
        tmb_pkg::OP_SCALE: begin
          op[0] = t.arg_a; op[5] = t.arg_b; op[10] = t.arg_c;
        end
        tmb_pkg::OP_ROTX: begin
          sine_cosine(t.arg_a, sn, cs);
          op[5] = cs; op[9] = -sn; op[6] = sn; op[10] = cs;
        end
        tmb_pkg::OP_ROTY: begin
          sine_cosine(t.arg_a, sn, cs);
          op[0] = cs; op[8] = sn; op[2] = -sn; op[10] = cs;
        end
        default: begin
          sine_cosine(t.arg_a, sn, cs);
          op[0] = cs; op[4] = -sn; op[1] = sn; op[5] = cs;
        end
      endcase
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += round_mul(op[r*4+k], mat[k*4+c]);
          nxt[r*4+c] = sat32(acc);
        end
      mat = nxt;
    end
  endtask

  // Driver: offers the head of the queue, holds it until accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_transaction(in_data);
        accepted++;
        void'(pending_q.pop_front());
      end
      if (in_valid && in_stall) begin
        // Payload stays put while stalled.
      end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold in the third phase, counted here in cycles.
  initial begin
    long_hold = 1'b0;
    wait (phase_num == 2);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Monitor: checks results and drives the receiver stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex result %h", $time, out_data);
          errors++;
        end else begin
          tmb_pkg::out_item_t e;
          e = vertex_q.pop_front();
          vertex_count++;
          if (e.out_x !== out_data.out_x)
            $display("%0t: out_x expected %h actual %h", $time, e.out_x, out_data.out_x);
          if (e.out_y !== out_data.out_y)
            $display("%0t: out_y expected %h actual %h", $time, e.out_y, out_data.out_y);
          if (e.out_z !== out_data.out_z)
            $display("%0t: out_z expected %h actual %h", $time, e.out_z, out_data.out_z);
          if (e.out_w !== out_data.out_w)
            $display("%0t: out_w expected %h actual %h", $time, e.out_w, out_data.out_w);
          if (e !== out_data) errors++;
        end
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic signed [31:0] rand_arg();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(2) == 0 ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(262143)) - 32'sd131072;
    endcase
  endfunction

  function automatic tmb_pkg::in_item_t make_item(logic [2:0] opc, logic signed [31:0] a,
                                                  logic signed [31:0] b,
                                                  logic signed [31:0] c,
                                                  logic signed [31:0] d);
    tmb_pkg::in_item_t t;
    t.opcode = opc; t.arg_a = a; t.arg_b = b; t.arg_c = c; t.arg_d = d;
    return t;
  endfunction

  function automatic tmb_pkg::in_item_t random_item();
    tmb_pkg::in_item_t t;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) t.opcode = tmb_pkg::OP_VERTEX;
    else if (pick < 40) t.opcode = tmb_pkg::OP_IDENT;
    else if (pick < 43) t.opcode = 3'd7;
    else t.opcode = 3'($urandom_range(tmb_pkg::OP_ROTZ, tmb_pkg::OP_TRANS));
    t.arg_a = rand_arg(); t.arg_b = rand_arg();
    t.arg_c = rand_arg(); t.arg_d = rand_arg();
    // Keep scales near unity most of the time so the matrix stays useful.
    if (t.opcode == tmb_pkg::OP_SCALE && $urandom_range(3) != 0) begin
      t.arg_a = $signed($urandom_range(98304, 32768)) * ($urandom_range(1) ? 1 : -1);
      t.arg_b = $signed($urandom_range(98304, 32768));
      t.arg_c = $signed($urandom_range(98304, 32768));
    end
    // Mostly moderate translations so the matrix does not drift into saturation.
    if (t.opcode == tmb_pkg::OP_TRANS && $urandom_range(3) != 0) begin
      t.arg_a = $signed($urandom_range(2097151)) - 32'sd1048576;
    end
    if (t.opcode >= tmb_pkg::OP_ROTX && t.opcode <= tmb_pkg::OP_ROTZ && $urandom_range(1))
      t.arg_a = $signed($urandom_range(47185920)) - 32'sd23592960;
    return t;
  endfunction

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || vertex_q.size() != 0) @(posedge clk);
  endtask

  // Stimulus sequence.
  initial begin
    rst_n = 1'b0;
    for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset identity, every opcode, field extremes, angle corners.
    pending_q.push_back(make_item(tmb_pkg::OP_VERTEX, 32'sh7fffffff, 32'sh80000000, 0,
                                  32'sh10000));
    pending_q.push_back(make_item(3'd7, 32'sh7fffffff, 1, 2, 3));
    pending_q.push_back(make_item(tmb_pkg::OP_VERTEX, 32'sh10000, 32'sh20000, -32'sh30000,
                                  32'sh10000));
    pending_q.push_back(make_item(tmb_pkg::OP_TRANS, 32'sh50000, -32'sh20000, 32'sh7fffffff,
                                  0));
    pending_q.push_back(make_item(tmb_pkg::OP_VERTEX, 32'sh10000, 32'sh10000, 32'sh10000,
                                  32'sh10000));
    pending_q.push_back(make_item(tmb_pkg::OP_SCALE, 32'sh80000000, 32'sh7fffffff, 0, 0));
    pending_q.push_back(make_item(tmb_pkg::OP_VERTEX, 32'sh7fffffff, 32'sh7fffffff,
                                  32'sh7fffffff, 32'sh80000000));
    pending_q.push_back(make_item(tmb_pkg::OP_IDENT, 32'shffffffff, 32'shffffffff,
                                  32'shffffffff, 32'shffffffff));
    pending_q.push_back(make_item(tmb_pkg::OP_ROTX, 32'sh5a0000, 0, 0, 0));
    pending_q.push_back(make_item(tmb_pkg::OP_ROTY, -32'sh5a0000, 0, 0, 0));
    pending_q.push_back(make_item(tmb_pkg::OP_ROTZ, 32'shb40000, 0, 0, 0));
    pending_q.push_back(make_item(tmb_pkg::OP_VERTEX, 32'sh10000, 32'sh20000, 32'sh30000,
                                  32'sh10000));
    pending_q.push_back(make_item(tmb_pkg::OP_ROTZ, -32'shb40000, 0, 0, 0));
    pending_q.push_back(make_item(tmb_pkg::OP_ROTX, 32'sh7fffffff, 0, 0, 0));
    pending_q.push_back(make_item(tmb_pkg::OP_ROTY, 32'sh80000000, 0, 0, 0));
    pending_q.push_back(make_item(tmb_pkg::OP_ROTZ, 32'sh1680000, 0, 0, 0));
    pending_q.push_back(make_item(tmb_pkg::OP_ROTX, 32'sh5a0001, 0, 0, 0));
    pending_q.push_back(make_item(tmb_pkg::OP_VERTEX, -32'sh10000, 32'sh8000, 32'sh4000,
                                  32'sh10000));
    pending_q.push_back(make_item(tmb_pkg::OP_IDENT, 0, 0, 0, 0));
    wait_drained();

    // Random phases with different idle patterns.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 17 : 0;
      recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 17 : 0;
      phase_num = ph;
      for (int i = 0; i < 170; i++) pending_q.push_back(random_item());
      wait_drained();
      // Sender pause until everything is delivered.
      while (vertex_q.size() != 0) @(posedge clk);
    end
    repeat (300) @(posedge clk);

    $display("Ran %0d transactions through all opcodes; %0d vertex results checked.",
             accepted, vertex_count);
    if (errors == 0 && vertex_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tmb_pkg.sv
hw/rtl/tmb_ctrl.sv
hw/rtl/tmb_dp.sv
hw/rtl/transform_matrix_builder.sv
hw/rtl/tmb_checker.sv
test/tb_transform_matrix_builder.sv
